@@ rtl/ccse_pkg.sv @@
// shared types, constants and helpers of the contour segment extractor
package ccse_pkg;

	localparam int GRID_CELLS = 256;
	localparam int VAL_W = 32;
	localparam int COORD_W = 40;
	localparam int SPAN_W = 31;
	localparam int IDX_W = 8;
	localparam int REG_IDX_W = 8;

	localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT = 8'd1;

	localparam logic [2:0] VTX_CENTRE = 3'd4;

	typedef struct packed {
		logic [3:0][VAL_W-1:0] corner;
		logic [VAL_W-1:0] cen;
		logic [VAL_W-1:0] lev;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] xc;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y2;
		logic [COORD_W-1:0] yc;
		logic [3:0] tri_mask;
	} ccse_task_t;

	typedef struct packed {
		logic [VAL_W-1:0] x1;
		logic [VAL_W-1:0] y1;
		logic [VAL_W-1:0] x2;
		logic [VAL_W-1:0] y2;
		logic [1:0] tri_idx;
		logic last;
	} ccse_seg_t;

	function automatic logic crosses(logic signed [VAL_W-1:0] p, logic signed [VAL_W-1:0] q,
			logic signed [VAL_W-1:0] lev);
		return ((p <= lev) && (lev < q)) || ((p >= lev) && (lev > q));
	endfunction

endpackage

@@ rtl/ccse_front.sv @@
// front part: registers a cell, derives centre, coordinates and triangle mask
module ccse_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [31:0] corner_a,
	input  logic [31:0] corner_b,
	input  logic [31:0] corner_c,
	input  logic [31:0] corner_d,
	input  logic [7:0] cell_col,
	input  logic [7:0] cell_row,
	input  logic [31:0] contour_level,
	input  logic [30:0] cell_width,
	input  logic [30:0] cell_height,
	output logic task_valid,
	input  logic task_ready,
	output ccse_pkg::ccse_task_t task_data
);

	logic valid_s1;
	logic [3:0][31:0] corner_s1;
	logic [7:0] col_s1;
	logic [7:0] row_s1;
	logic [31:0] lev_s1;

	logic [7:0] col;
	logic [7:0] row;
	logic [38:0] xm;
	logic [38:0] ym;
	logic [40:0] xsum;
	logic [40:0] ysum;
	logic signed [33:0] sum;
	logic [3:0] side;
	logic [3:0] spoke;
	logic take;
	logic accept;

	always_comb begin
		col = 8'(col_s1 % ccse_pkg::GRID_CELLS);
		row = 8'(row_s1 % ccse_pkg::GRID_CELLS);
		xm = 39'(col) * 39'(cell_width);
		ym = 39'(row) * 39'(cell_height);
		task_data.x0 = {1'b0, xm};
		task_data.y0 = {1'b0, ym};
		task_data.x2 = {1'b0, xm} + 40'(cell_width);
		task_data.y2 = {1'b0, ym} + 40'(cell_height);
		xsum = 41'(task_data.x0) + 41'(task_data.x2);
		ysum = 41'(task_data.y0) + 41'(task_data.y2);
		task_data.xc = xsum[40:1];
		task_data.yc = ysum[40:1];
		sum = 34'($signed(corner_s1[0])) + 34'($signed(corner_s1[1]))
			+ 34'($signed(corner_s1[2])) + 34'($signed(corner_s1[3]));
		task_data.cen = sum[33:2];
		task_data.corner = corner_s1;
		task_data.lev = lev_s1;
		for (int k = 0; k < 4; k++) begin
			side[k] = ccse_pkg::crosses(corner_s1[k], corner_s1[(k + 1) % 4], lev_s1);
			spoke[k] = ccse_pkg::crosses(corner_s1[k], task_data.cen, lev_s1);
		end
		for (int m = 0; m < 4; m++) begin
			task_data.tri_mask[m] = (side[m] & spoke[m]) | (side[m] & spoke[(m + 1) % 4])
				| (spoke[m] & spoke[(m + 1) % 4]);
		end
		task_valid = valid_s1 & (|task_data.tri_mask);
		take = valid_s1 & (~(|task_data.tri_mask) | task_ready);
		full = valid_s1 & ~take;
		accept = push & ~full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corner_s1 <= {corner_d, corner_c, corner_b, corner_a};
			col_s1 <= cell_col;
			row_s1 <= cell_row;
			lev_s1 <= contour_level;
		end
	end

endmodule

@@ rtl/ccse_fifo.sv @@
// short queue of classified cells between front and back
module ccse_fifo #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ccse_pkg::ccse_task_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ccse_pkg::ccse_task_t out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ccse_pkg::ccse_task_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic wr;
	logic rd;

	assign in_ready = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data = mem_q[rd_ptr_q];
	assign wr = in_valid & in_ready;
	assign rd = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ rtl/ccse_interp.sv @@
// iterative scale-and-divide unit, one span bit per cycle, saturated result
module ccse_interp (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [30:0] am,
	input  logic [32:0] an,
	input  logic [32:0] ad,
	input  logic [39:0] base,
	input  logic neg,
	output logic done,
	output logic [31:0] result
);

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [30:0] am_q;
	logic [32:0] an_q;
	logic [32:0] ad_q;
	logic [39:0] base_q;
	logic neg_q;
	logic [32:0] r_q;
	logic [31:0] q_q;

	logic [34:0] r2;
	logic [34:0] ad1;
	logic [34:0] ad2;
	logic [34:0] r_nxt;
	logic [31:0] q_nxt;
	logic signed [41:0] v;

	always_comb begin
		r2 = {1'b0, r_q, 1'b0} + (am_q[30] ? 35'(an_q) : 35'd0);
		ad1 = 35'(ad_q);
		ad2 = {1'b0, ad_q, 1'b0};
		if (r2 >= ad2) begin
			r_nxt = r2 - ad2;
			q_nxt = {q_q[30:0], 1'b0} + 32'd2;
		end else if (r2 >= ad1) begin
			r_nxt = r2 - ad1;
			q_nxt = {q_q[30:0], 1'b0} + 32'd1;
		end else begin
			r_nxt = r2;
			q_nxt = {q_q[30:0], 1'b0};
		end
		v = neg_q ? ($signed({2'b00, base_q}) - $signed({10'd0, q_q}))
			: ($signed({2'b00, base_q}) + $signed({10'd0, q_q}));
		result = (v > 42'sd2147483647) ? 32'h7fff_ffff : v[31:0];
		done = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd30;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q <= am;
			an_q <= an;
			ad_q <= ad;
			base_q <= base;
			neg_q <= neg;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			am_q <= {am_q[29:0], 1'b0};
			r_q <= r_nxt[32:0];
			q_q <= q_nxt;
		end
	end

endmodule

@@ rtl/ccse_back.sv @@
// back part: walks the triangles of a cell, interpolates crossings, emits segments
module ccse_back (
	input  logic clk,
	input  logic arst_n,
	input  logic task_valid,
	output logic task_ready,
	input  ccse_pkg::ccse_task_t task_data,
	output logic seg_valid,
	input  logic seg_pop,
	output ccse_pkg::ccse_seg_t seg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EDGE = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	ccse_pkg::ccse_task_t task_q;
	logic [1:0] m_q;
	logic [1:0] e_q;
	logic found_q;
	logic [31:0] p0x_q;
	logic [31:0] p0y_q;
	logic [31:0] p1x_q;
	logic [31:0] p1y_q;
	logic out_valid_q;
	ccse_pkg::ccse_seg_t seg_q;

	logic [2:0] u_idx;
	logic [2:0] v_idx;
	logic [31:0] pu;
	logic [31:0] pv;
	logic [39:0] xs;
	logic [39:0] xt;
	logic [39:0] ys;
	logic [39:0] yt;
	logic signed [32:0] dn;
	logic signed [32:0] dd;
	logic signed [40:0] dx;
	logic signed [40:0] dy;
	logic [32:0] an;
	logic [32:0] ad;
	logic [40:0] amx;
	logic [40:0] amy;
	logic edge_hit;
	logic start;
	logic done_x;
	logic done_y;
	logic [31:0] res_x;
	logic [31:0] res_y;
	logic [3:0] sh;
	logic can_emit;

	function automatic logic [31:0] vtx_val(ccse_pkg::ccse_task_t t, logic [2:0] i);
		return (i == ccse_pkg::VTX_CENTRE) ? t.cen : t.corner[i[1:0]];
	endfunction

	function automatic logic [39:0] vtx_x(ccse_pkg::ccse_task_t t, logic [2:0] i);
		logic [39:0] r;
		unique case (i)
			3'd0, 3'd1: r = t.x0;
			3'd2, 3'd3: r = t.x2;
			default: r = t.xc;
		endcase
		return r;
	endfunction

	function automatic logic [39:0] vtx_y(ccse_pkg::ccse_task_t t, logic [2:0] i);
		logic [39:0] r;
		unique case (i)
			3'd0, 3'd3: r = t.y0;
			3'd1, 3'd2: r = t.y2;
			default: r = t.yc;
		endcase
		return r;
	endfunction

	always_comb begin
		u_idx = (e_q == 2'd2) ? {1'b0, m_q + 2'd1} : {1'b0, m_q};
		v_idx = (e_q == 2'd0) ? {1'b0, m_q + 2'd1} : ccse_pkg::VTX_CENTRE;
		pu = vtx_val(task_q, u_idx);
		pv = vtx_val(task_q, v_idx);
		xs = vtx_x(task_q, u_idx);
		xt = vtx_x(task_q, v_idx);
		ys = vtx_y(task_q, u_idx);
		yt = vtx_y(task_q, v_idx);
		dn = $signed({task_q.lev[31], task_q.lev}) - $signed({pu[31], pu});
		dd = $signed({pv[31], pv}) - $signed({pu[31], pu});
		an = dn[32] ? 33'(-dn) : 33'(dn);
		ad = dd[32] ? 33'(-dd) : 33'(dd);
		dx = $signed({1'b0, xt}) - $signed({1'b0, xs});
		dy = $signed({1'b0, yt}) - $signed({1'b0, ys});
		amx = dx[40] ? 41'(-dx) : 41'(dx);
		amy = dy[40] ? 41'(-dy) : 41'(dy);
		edge_hit = ccse_pkg::crosses(pu, pv, task_q.lev);
		start = (state_q == ST_EDGE) & task_q.tri_mask[m_q] & edge_hit;
		sh = task_q.tri_mask >> m_q;
		can_emit = ~out_valid_q | seg_pop;
		task_ready = (state_q == ST_IDLE);
		seg_valid = out_valid_q;
		seg = seg_q;
	end

	ccse_interp u_interp_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.am(amx[30:0]),
		.an(an),
		.ad(ad),
		.base(xs),
		.neg(dx[40]),
		.done(done_x),
		.result(res_x)
	);

	ccse_interp u_interp_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.am(amy[30:0]),
		.an(an),
		.ad(ad),
		.base(ys),
		.neg(dy[40]),
		.done(done_y),
		.result(res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q <= '0;
			e_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seg_pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (task_valid) begin
						state_q <= ST_EDGE;
						m_q <= '0;
						e_q <= '0;
						found_q <= 1'b0;
					end
				end
				ST_EDGE: begin
					if (!task_q.tri_mask[m_q]) begin
						m_q <= m_q + 2'd1;
						e_q <= '0;
						found_q <= 1'b0;
						if (m_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end else if (edge_hit) begin
						state_q <= ST_WAIT;
					end else begin
						e_q <= e_q + 2'd1;
					end
				end
				ST_WAIT: begin
					if (done_x & done_y) begin
						if (!found_q) begin
							found_q <= 1'b1;
							e_q <= e_q + 2'd1;
							state_q <= ST_EDGE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						m_q <= m_q + 2'd1;
						e_q <= '0;
						found_q <= 1'b0;
						state_q <= (m_q == 2'd3) ? ST_IDLE : ST_EDGE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && task_valid) begin
			task_q <= task_data;
		end
		if (state_q == ST_WAIT && done_x && done_y) begin
			if (!found_q) begin
				p0x_q <= res_x;
				p0y_q <= res_y;
			end else begin
				p1x_q <= res_x;
				p1y_q <= res_y;
			end
		end
		if (state_q == ST_EMIT && can_emit) begin
			seg_q.x1 <= p0x_q;
			seg_q.y1 <= p0y_q;
			seg_q.x2 <= p1x_q;
			seg_q.y2 <= p1y_q;
			seg_q.tri_idx <= m_q;
			seg_q.last <= ~(|sh[3:1]);
		end
	end

endmodule

@@ rtl/cell_contour_segment_extract.sv @@
// top level of the marching-triangles contour segment extractor
//
// a cell (four corners, column, row, level) is taken when push is high and full low.
// segments come out oldest first: while empty is low the ports hold one segment,
// and it leaves on a clock edge with pop high. cell_width and cell_height are
// written through wr_en / wr_index / wr_data; the user must write them only while
// the block is idle, which the block itself does not enforce. the front registers
// a cell, works out centre, coordinates and which of the four triangles carry two
// crossings, and drops cells without a segment. a two-entry queue lets the front
// take new cells while the back is busy. the back takes a cell in ST_IDLE and, in
// ST_EDGE, steps past each triangle without a segment and tests the edges of the
// others one by one; each crossing starts the bit-serial scale-and-divide units
// (x and y side by side) and waits for them in ST_WAIT, and each segment is loaded
// into the output register in ST_EMIT. the divide loop sets the rate, and the back
// takes no new cell before it is back in ST_IDLE. while pop stays low the back
// holds its finished segment and stops; the queue fills and then full rises. reset
// clears all control state, empties the queue and sets both spacings to 1.0.
module cell_contour_segment_extract (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [31:0] corner_a,
	input  logic [31:0] corner_b,
	input  logic [31:0] corner_c,
	input  logic [31:0] corner_d,
	input  logic [7:0] cell_col,
	input  logic [7:0] cell_row,
	input  logic [31:0] contour_level,
	output logic empty,
	input  logic pop,
	output logic [31:0] seg_x1,
	output logic [31:0] seg_y1,
	output logic [31:0] seg_x2,
	output logic [31:0] seg_y2,
	output logic [1:0] triangle_index,
	output logic last_segment,
	input  logic wr_en,
	input  logic [7:0] wr_index,
	input  logic [30:0] wr_data
);

	logic [30:0] cell_width_q;
	logic [30:0] cell_height_q;
	logic front_valid;
	logic front_ready;
	ccse_pkg::ccse_task_t front_data;
	logic back_valid;
	logic back_ready;
	ccse_pkg::ccse_task_t back_data;
	logic seg_valid;
	ccse_pkg::ccse_seg_t seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q <= 31'd65536;
			cell_height_q <= 31'd65536;
		end else if (wr_en) begin
			if (wr_index == ccse_pkg::REG_CELL_WIDTH) begin
				cell_width_q <= wr_data;
			end else if (wr_index == ccse_pkg::REG_CELL_HEIGHT) begin
				cell_height_q <= wr_data;
			end
		end
	end

	ccse_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.corner_d(corner_d),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.contour_level(contour_level),
		.cell_width(cell_width_q),
		.cell_height(cell_height_q),
		.task_valid(front_valid),
		.task_ready(front_ready),
		.task_data(front_data)
	);

	ccse_fifo #(
		.DEPTH(2)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(front_valid),
		.in_ready(front_ready),
		.in_data(front_data),
		.out_valid(back_valid),
		.out_ready(back_ready),
		.out_data(back_data)
	);

	ccse_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.task_valid(back_valid),
		.task_ready(back_ready),
		.task_data(back_data),
		.seg_valid(seg_valid),
		.seg_pop(pop & seg_valid),
		.seg(seg)
	);

	assign empty = ~seg_valid;
	assign seg_x1 = seg.x1;
	assign seg_y1 = seg.y1;
	assign seg_x2 = seg.x2;
	assign seg_y2 = seg.y2;
	assign triangle_index = seg.tri_idx;
	assign last_segment = seg.last;

endmodule

@@ tb/testbench.sv @@
// testbench for the contour segment extractor: directed and random cells checked against a predictor
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] y1;
		logic [31:0] x2;
		logic [31:0] y2;
		logic [1:0] tri_idx;
		logic last;
	} segment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [31:0] corner_a = '0, corner_b = '0, corner_c = '0, corner_d = '0;
	logic [7:0] cell_col = '0, cell_row = '0;
	logic [31:0] contour_level = '0;
	logic empty;
	logic pop = 1'b0;
	logic [31:0] seg_x1, seg_y1, seg_x2, seg_y2;
	logic [1:0] triangle_index;
	logic last_segment;
	logic wr_en = 1'b0;
	logic [7:0] wr_index = '0;
	logic [30:0] wr_data = '0;

	segment_t expected_segs[$];
	longint span_x, span_y;
	int mismatches = 0;
	int seg_count = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;

	cell_contour_segment_extract uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic bit level_crossed(longint p, longint q, longint lev);
		return (p <= lev && lev < q) || (p >= lev && lev > q);
	endfunction

	function automatic longint lerp_coord(longint p, longint q, longint lev, longint s,
			longint t);
		longint num, den, d;
		longint unsigned an, ad, am, off;
		num = lev - p;
		den = q - p;
		d = t - s;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		am = d < 0 ? -d : d;
		if (ad == 0) return s;
		off = (am * an) / ad;
		return d < 0 ? s - longint'(off) : s + longint'(off);
	endfunction

	task automatic predict_segments(logic [31:0] a, b, c, d, logic [7:0] col, row,
			logic [31:0] lvl);
		longint pv[6], xv[6], yv[6];
		longint lev, sum, cen, px[2], py[2];
		int ea[3], eb[3];
		int found, u, v, first;
		segment_t s;
		ea = '{0, 0, 1};
		eb = '{1, 5, 5};
		first = expected_segs.size();
		pv[0] = longint'(signed'(a));
		pv[1] = longint'(signed'(b));
		pv[2] = longint'(signed'(c));
		pv[3] = longint'(signed'(d));
		lev = longint'(signed'(lvl));
		xv[0] = col * span_x;
		yv[0] = row * span_y;
		xv[1] = xv[0];
		yv[1] = (row + 1) * span_y;
		xv[2] = (col + 1) * span_x;
		yv[2] = yv[1];
		xv[3] = xv[2];
		yv[3] = yv[0];
		pv[4] = pv[0];
		xv[4] = xv[0];
		yv[4] = yv[0];
		sum = pv[0] + pv[1] + pv[2] + pv[3];
		cen = sum >>> 2;
		pv[5] = cen;
		xv[5] = ((2 * col + 1) * span_x) >> 1;
		yv[5] = ((2 * row + 1) * span_y) >> 1;
		for (int m = 0; m < 4; m++) begin
			found = 0;
			for (int e = 0; e < 3 && found < 2; e++) begin
				u = m + ea[e];
				v = (eb[e] == 5) ? 5 : m + eb[e];
				if (level_crossed(pv[u], pv[v], lev)) begin
					px[found] = lerp_coord(pv[u], pv[v], lev, xv[u], xv[v]);
					py[found] = lerp_coord(pv[u], pv[v], lev, yv[u], yv[v]);
					found++;
				end
			end
			if (found == 2) begin
				s.x1 = clamp32(px[0]);
				s.y1 = clamp32(py[0]);
				s.x2 = clamp32(px[1]);
				s.y2 = clamp32(py[1]);
				s.tri_idx = 2'(m);
				s.last = 1'b0;
				expected_segs.push_back(s);
			end
		end
		if (expected_segs.size() > first)
			expected_segs[expected_segs.size() - 1].last = 1'b1;
	endtask

	task automatic send_cell(logic [31:0] a, b, c, d, logic [7:0] col, row,
			logic [31:0] lvl);
		int idle;
		idle = $urandom_range(0, 3);
		if (idle != 0) begin
			push <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		push <= 1'b1;
		corner_a <= a;
		corner_b <= b;
		corner_c <= c;
		corner_d <= d;
		cell_col <= col;
		cell_row <= row;
		contour_level <= lvl;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_segments(a, b, c, d, col, row, lvl);
	endtask

	task automatic drain;
		push <= 1'b0;
		while (expected_segs.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [30:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == ccse_pkg::REG_CELL_WIDTH) span_x = val;
		else if (idx == ccse_pkg::REG_CELL_HEIGHT) span_y = val;
		@(posedge clk);
	endtask

	// result side
	always @(posedge clk) begin
		segment_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{seg_x1, seg_y1, seg_x2, seg_y2, triangle_index, last_segment};
			seg_count++;
			if (expected_segs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected segment %p", got);
			end else begin
				want = expected_segs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
		if (hold_off) pop <= 1'b0;
		else pop <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 8) << 16;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'(4'($urandom))};
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	task automatic random_cells(int n);
		logic [31:0] a, b, c, d, l;
		for (int k = 0; k < n; k++) begin
			a = rand_val();
			b = rand_val();
			c = rand_val();
			d = rand_val();
			case ($urandom_range(0, 3))
				0: l = $urandom;
				1: l = a;
				2: l = ({32{a[31]}} & 32'h0) + (signed'(a) >>> 1) + (signed'(c) >>> 1);
				default: l = rand_val();
			endcase
			send_cell(a, b, c, d, 8'($urandom), 8'($urandom), l);
		end
	endtask

	task automatic test_directed;
		send_cell(32'h00000000, 32'h00010000, 32'h00020000, 32'h00010000, 8'd0, 8'd0,
			32'h00008000);
		send_cell(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 8'd1, 8'd1,
			32'h00010000);
		send_cell(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 8'd255, 8'd255,
			32'd0);
		send_cell(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 8'd0, 8'd255,
			32'h80000000);
		send_cell(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'd255, 8'd0,
			32'h7fffffff);
		send_cell(32'hffffffff, 32'hfffffffe, 32'h00000000, 32'h00000001, 8'd7, 8'd3, 32'd0);
		send_cell(32'h00030000, 32'd0, 32'd0, 32'd0, 8'd4, 8'd5, 32'h00010000);
		send_cell(32'd0, 32'h00030000, 32'h00030000, 32'h00030000, 8'd9, 8'd2, 32'h00010000);
		send_cell(32'h00020000, 32'd0, 32'h00020000, 32'd0, 8'd100, 8'd200, 32'h00010000);
		send_cell(32'hfffffffd, 32'hfffffffe, 32'hffffffff, 32'h00000003, 8'd12, 8'd34,
			32'hffffffff);
		send_cell(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 8'd128, 8'd127,
			32'hffffffff);
		drain();
	endtask

	task automatic test_spacings;
		write_reg(ccse_pkg::REG_CELL_WIDTH, 31'h7fffffff);
		write_reg(ccse_pkg::REG_CELL_HEIGHT, 31'd1);
		random_cells(40);
		drain();
		write_reg(ccse_pkg::REG_CELL_WIDTH, 31'd0);
		write_reg(ccse_pkg::REG_CELL_HEIGHT, 31'h7fffffff);
		random_cells(30);
		drain();
		write_reg(8'd7, 31'd12345);
		write_reg(ccse_pkg::REG_CELL_WIDTH, 31'($urandom));
		write_reg(ccse_pkg::REG_CELL_HEIGHT, 31'($urandom));
		random_cells(30);
		drain();
		write_reg(ccse_pkg::REG_CELL_WIDTH, 31'h00008000);
		write_reg(ccse_pkg::REG_CELL_HEIGHT, 31'h00030000);
	endtask

	task automatic test_back_pressure;
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			random_cells(20);
		join
		drain();
	endtask

	initial begin
		span_x = 65536;
		span_y = 65536;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_spacings();
		random_cells(289);
		drain();
		if (mismatches == 0 && expected_segs.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
